// ----- hw/rtl/msd_pkg.sv -----
// Shared types, codes and constants of the motion segment detector.
package msd_pkg;

   // Default sizes of the block.
   localparam int DEFAULT_NUM_DEVICES  = 4;
   localparam int DEFAULT_BUFFER_DEPTH = 64;

   // Width of a squared step distance: three squared byte differences.
   localparam int DIST_W = 18;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 18;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SEGMENT_LEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_DEVICES  = 2'd2;

   // Register reset values.
   localparam logic [17:0] DIST_THRESHOLD_RESET  = 18'(12 * 12);
   localparam logic [6:0]  MIN_SEGMENT_LEN_RESET = 7'd5;
   localparam logic [2:0]  ACTIVE_DEVICES_RESET  = 3'd4;

   // Actions.
   localparam logic [2:0] ACT_SAMPLE = 3'd0;
   localparam logic [2:0] ACT_START  = 3'd1;
   localparam logic [2:0] ACT_STOP   = 3'd2;
   localparam logic [2:0] ACT_READ   = 3'd3;
   localparam logic [2:0] ACT_QUERY  = 3'd4;

   // Device states, also reported as state codes.
   localparam logic [2:0] ST_NONE        = 3'd0;
   localparam logic [2:0] ST_MOVING      = 3'd1;
   localparam logic [2:0] ST_FINISHED    = 3'd2;
   localparam logic [2:0] ST_OUT_OF_BUF  = 3'd3;
   localparam logic [2:0] ST_MANUAL      = 3'd4;
   localparam logic [2:0] ST_MANUAL_FULL = 3'd5;
   localparam logic [2:0] ST_MANUAL_DONE = 3'd6;
   localparam logic [2:0] ST_ERROR       = 3'd7;

   // One stored 3-axis sample, x in the low byte.
   typedef struct packed {
      logic [7:0] z;
      logic [7:0] y;
      logic [7:0] x;
   } sample_type;

   // Reset content of the last slot of every device ring.
   localparam sample_type RESET_LAST_SLOT = '{z: 8'(128 + 25), y: 8'd128, x: 8'd128};

   // Input item.
   typedef struct packed {
      logic [2:0] action;
      logic [1:0] device_id;
      logic [7:0] accel_x;
      logic [7:0] accel_y;
      logic [7:0] accel_z;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [2:0] state_code;
      logic       ok;
      logic       has_sample;
      logic [7:0] sample_x;
      logic [7:0] sample_y;
      logic [7:0] sample_z;
      logic       last;
   } rsp_type;

endpackage

// ----- hw/rtl/msd_dist_unit.sv -----
// Squared step distance between two samples, with registered squares.
module msd_dist_unit (
   input  logic                          clock,
   input  msd_pkg::sample_type           cur_sample,
   input  msd_pkg::sample_type           prev_sample,
   output logic [msd_pkg::DIST_W-1:0]    dist_sq
);

   logic [7:0]  diff_x, diff_y, diff_z;
   logic [15:0] sq_x_ff, sq_y_ff, sq_z_ff;

   // Absolute difference per axis.
   assign diff_x = (cur_sample.x > prev_sample.x) ? cur_sample.x - prev_sample.x
                                                  : prev_sample.x - cur_sample.x;
   assign diff_y = (cur_sample.y > prev_sample.y) ? cur_sample.y - prev_sample.y
                                                  : prev_sample.y - cur_sample.y;
   assign diff_z = (cur_sample.z > prev_sample.z) ? cur_sample.z - prev_sample.z
                                                  : prev_sample.z - cur_sample.z;

   // One 8x8 square per axis, registered.
   always_ff @(posedge clock) begin
      sq_x_ff <= diff_x * diff_x;
      sq_y_ff <= diff_y * diff_y;
      sq_z_ff <= diff_z * diff_z;
   end

   // Sum of the squares after the register.
   assign dist_sq = msd_pkg::DIST_W'(sq_x_ff) + msd_pkg::DIST_W'(sq_y_ff)
                  + msd_pkg::DIST_W'(sq_z_ff);

endmodule

// ----- hw/rtl/motion_segment_detector.sv -----
// Top level of the motion segment detector: sequencer, sample memory and device state.
// An automatic-mode sample passes through the decode, distance and update states to its
// result; manual samples, start, stop without read-out and queries are answered from decode.
// A read-out takes one memory read state and one load state per sample.
// One item is in work at a time. After reset a clearing pass writes every one of the
// 2**(device bits + slot bits) sample slots (256 by default) before the first item transfer.
module motion_segment_detector #(
   parameter int NUM_DEVICES  = msd_pkg::DEFAULT_NUM_DEVICES,
   parameter int BUFFER_DEPTH = msd_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  msd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output msd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [msd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [msd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DEV_W     = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam int IW        = $clog2(BUFFER_DEPTH);
   localparam int CW        = $clog2(BUFFER_DEPTH + 1);
   localparam int AW        = DEV_W + IW;
   localparam int MEM_DEPTH = 2 ** AW;
   localparam logic [IW-1:0] LAST_IDX  = IW'(BUFFER_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(BUFFER_DEPTH);
   localparam logic [4:0]    DEV_LIMIT = 5'(NUM_DEVICES);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_DIST   = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;
   localparam logic [2:0] S_RD     = 3'd5;
   localparam logic [2:0] S_LD     = 3'd6;

   // Configuration registers.
   logic [17:0] dist_threshold_ff;
   logic [6:0]  min_segment_len_ff;
   logic [2:0]  active_devices_ff;

   // Sequencer and item registers.
   logic [2:0]       state_ff, state_in;
   msd_pkg::req_type item_ff;
   logic [AW-1:0]    clr_ff, clr_in;

   // Per-device state.
   logic [2:0]    mode_ff  [NUM_DEVICES];
   logic [IW-1:0] start_ff [NUM_DEVICES];
   logic [IW-1:0] end_ff   [NUM_DEVICES];
   logic          upd_en;
   logic [2:0]    upd_mode;
   logic [IW-1:0] upd_start, upd_end;

   // Read-out run.
   logic [IW-1:0] run_idx_ff, run_idx_in;
   logic [CW-1:0] run_left_ff, run_left_in;
   logic [2:0]    run_state_ff, run_state_in;

   // Sample memory.
   msd_pkg::sample_type mem [MEM_DEPTH];
   msd_pkg::sample_type mem_rd_ff;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   msd_pkg::sample_type mem_wdata;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   msd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             out_free;
   logic             emit;
   msd_pkg::rsp_type emit_data;

   // Decoded item.
   logic [DEV_W-1:0]      dev_ix;
   logic                  item_err;
   msd_pkg::sample_type   acc;
   logic [2:0]            cur_mode;
   logic [IW-1:0]         cur_start, cur_end;
   logic [IW-1:0]         prev_idx, next_idx, seg_base;
   logic [CW-1:0]         auto_size;
   logic [msd_pkg::DIST_W-1:0] dist_sq;

   // Segment length from start to end, the whole ring when they are equal.
   function automatic logic [CW-1:0] seg_size(input logic [IW-1:0] s, input logic [IW-1:0] e);
      logic [CW-1:0] r;
      if (e > s) begin
         r = CW'(e) - CW'(s);
      end else begin
         r = DEPTH_CNT - (CW'(s) - CW'(e));
      end
      return r;
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_threshold_ff  <= msd_pkg::DIST_THRESHOLD_RESET;
         min_segment_len_ff <= msd_pkg::MIN_SEGMENT_LEN_RESET;
         active_devices_ff  <= msd_pkg::ACTIVE_DEVICES_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            msd_pkg::CSR_DIST_THRESHOLD:  dist_threshold_ff  <= csr_wdata[17:0];
            msd_pkg::CSR_MIN_SEGMENT_LEN: min_segment_len_ff <= csr_wdata[6:0];
            msd_pkg::CSR_ACTIVE_DEVICES:  active_devices_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Item decode.
   assign dev_ix    = DEV_W'(item_ff.device_id);
   assign item_err  = (item_ff.action > msd_pkg::ACT_QUERY)
                   || ({1'b0, item_ff.device_id} >= active_devices_ff)
                   || ({3'b000, item_ff.device_id} >= DEV_LIMIT);
   assign acc       = '{z: item_ff.accel_z, y: item_ff.accel_y, x: item_ff.accel_x};
   assign cur_mode  = mode_ff[dev_ix];
   assign cur_start = start_ff[dev_ix];
   assign cur_end   = end_ff[dev_ix];
   assign prev_idx  = (cur_end != '0) ? cur_end - 1'b1 : LAST_IDX;
   assign next_idx  = (cur_end == LAST_IDX) ? '0 : cur_end + 1'b1;
   assign seg_base  = (cur_mode == msd_pkg::ST_FINISHED || cur_mode == msd_pkg::ST_OUT_OF_BUF)
                    ? cur_end : cur_start;
   assign auto_size = seg_size(seg_base, next_idx);

   // Step distance against the previously stored sample.
   msd_dist_unit u_dist (
      .clock       (clock),
      .cur_sample  (acc),
      .prev_sample (mem_rd_ff),
      .dist_sq     (dist_sq)
   );

   // The result register can take a new result this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      run_idx_in   = run_idx_ff;
      run_left_in  = run_left_ff;
      run_state_in = run_state_ff;
      upd_en       = 1'b0;
      upd_mode     = cur_mode;
      upd_start    = cur_start;
      upd_end      = cur_end;
      mem_we       = 1'b0;
      mem_waddr    = {dev_ix, cur_end};
      mem_wdata    = acc;
      mem_re       = 1'b0;
      mem_raddr    = {dev_ix, prev_idx};
      emit         = 1'b0;
      emit_data    = '0;
      emit_data.last = 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff[IW-1:0] == LAST_IDX) ? msd_pkg::RESET_LAST_SLOT : '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (item_err) begin
               if (out_free) begin
                  emit                 = 1'b1;
                  emit_data.state_code = msd_pkg::ST_ERROR;
                  state_in             = S_IDLE;
               end
            end else begin
               case (item_ff.action)
                  msd_pkg::ACT_SAMPLE: begin
                     if (cur_mode == msd_pkg::ST_MANUAL || cur_mode == msd_pkg::ST_MANUAL_FULL) begin
                        // Manual recording stores unconditionally and wraps to slot 0.
                        if (out_free) begin
                           mem_we   = 1'b1;
                           upd_en   = 1'b1;
                           upd_end  = next_idx;
                           upd_mode = (cur_end == LAST_IDX) ? msd_pkg::ST_MANUAL_FULL
                                                            : msd_pkg::ST_MANUAL;
                           emit                 = 1'b1;
                           emit_data.state_code = upd_mode;
                           state_in             = S_IDLE;
                        end
                     end else begin
                        // Store the new sample and fetch the previous one.
                        mem_we   = 1'b1;
                        mem_re   = 1'b1;
                        state_in = S_DIST;
                     end
                  end
                  msd_pkg::ACT_START: begin
                     if (out_free) begin
                        upd_en               = 1'b1;
                        upd_mode             = msd_pkg::ST_MANUAL;
                        upd_start            = '0;
                        upd_end              = '0;
                        emit                 = 1'b1;
                        emit_data.state_code = msd_pkg::ST_MANUAL;
                        emit_data.ok         = 1'b1;
                        state_in             = S_IDLE;
                     end
                  end
                  msd_pkg::ACT_STOP: begin
                     if (cur_mode != msd_pkg::ST_MANUAL && cur_mode != msd_pkg::ST_MANUAL_FULL) begin
                        if (out_free) begin
                           emit                 = 1'b1;
                           emit_data.state_code = cur_mode;
                           state_in             = S_IDLE;
                        end
                     end else if (cur_end == cur_start) begin
                        if (out_free) begin
                           upd_en               = 1'b1;
                           upd_mode             = msd_pkg::ST_NONE;
                           emit                 = 1'b1;
                           emit_data.state_code = msd_pkg::ST_NONE;
                           state_in             = S_IDLE;
                        end
                     end else begin
                        // Read out slots 0 up to the end of the recording.
                        upd_en       = 1'b1;
                        upd_mode     = msd_pkg::ST_MANUAL_DONE;
                        run_idx_in   = '0;
                        run_left_in  = CW'(cur_end);
                        run_state_in = msd_pkg::ST_MANUAL_DONE;
                        state_in     = S_RD;
                     end
                  end
                  msd_pkg::ACT_READ: begin
                     run_idx_in   = cur_start;
                     run_left_in  = seg_size(cur_start, cur_end);
                     run_state_in = cur_mode;
                     state_in     = S_RD;
                  end
                  default: begin
                     if (out_free) begin
                        emit                 = 1'b1;
                        emit_data.state_code = cur_mode;
                        state_in             = S_IDLE;
                     end
                  end
               endcase
            end
         end
         S_DIST: begin
            // The squares of the step are registered in this cycle.
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               upd_en    = 1'b1;
               upd_start = seg_base;
               upd_end   = next_idx;
               if (dist_sq > dist_threshold_ff) begin
                  if (cur_mode != msd_pkg::ST_MOVING) begin
                     upd_start = prev_idx;
                     upd_mode  = msd_pkg::ST_MOVING;
                  end else if (next_idx == seg_base) begin
                     upd_mode  = msd_pkg::ST_OUT_OF_BUF;
                  end else begin
                     upd_mode  = msd_pkg::ST_MOVING;
                  end
               end else if (7'(auto_size) >= min_segment_len_ff
                            && (cur_mode == msd_pkg::ST_MOVING
                                || cur_mode == msd_pkg::ST_OUT_OF_BUF)) begin
                  // The quiet sample closes the segment and is not part of it.
                  upd_mode = msd_pkg::ST_FINISHED;
                  upd_end  = cur_end;
               end else begin
                  upd_mode = msd_pkg::ST_NONE;
               end
               emit                 = 1'b1;
               emit_data.state_code = upd_mode;
               state_in             = S_IDLE;
            end
         end
         S_RD: begin
            mem_re    = 1'b1;
            mem_raddr = {dev_ix, run_idx_ff};
            state_in  = S_LD;
         end
         S_LD: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_data.state_code = run_state_ff;
               emit_data.ok         = 1'b1;
               emit_data.has_sample = 1'b1;
               emit_data.sample_x   = mem_rd_ff.x;
               emit_data.sample_y   = mem_rd_ff.y;
               emit_data.sample_z   = mem_rd_ff.z;
               emit_data.last       = (run_left_ff == CW'(1));
               run_idx_in           = (run_idx_ff == LAST_IDX) ? '0 : run_idx_ff + 1'b1;
               run_left_in          = run_left_ff - 1'b1;
               state_in             = (run_left_ff == CW'(1)) ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register next value.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < NUM_DEVICES; d++) begin
            mode_ff[d]  <= msd_pkg::ST_NONE;
            start_ff[d] <= '0;
            end_ff[d]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_en) begin
            mode_ff[dev_ix]  <= upd_mode;
            start_ff[dev_ix] <= upd_start;
            end_ff[dev_ix]   <= upd_end;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         item_ff <= req_data;
      end
      run_idx_ff   <= run_idx_in;
      run_left_ff  <= run_left_in;
      run_state_ff <= run_state_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Sample memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
